// File: hw/rtl/aled_pkg.sv
`timescale 1ns / 1ps

package aled_pkg;

    // encoded bytes per pixel: three channels, four bit pairs each
    localparam logic [3:0] BytesPerPixel  = 4'd12;
    localparam logic [3:0] LastColorByte  = 4'd11;

    // pixel queue between front and back, power of two deep
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // register map, index = paddr[4:2]
    localparam int PaddrW = 5;
    typedef enum logic [2:0] {
        REG_CODE_00    = 3'd0,
        REG_CODE_01    = 3'd1,
        REG_CODE_10    = 3'd2,
        REG_CODE_11    = 3'd3,
        REG_TRAILER    = 3'd4,
        REG_BRIGHTNESS = 3'd5
    } t_reg_idx;

    // register reset values
    localparam logic [7:0] RstCode00     = 8'h88;
    localparam logic [7:0] RstCode01     = 8'h8E;
    localparam logic [7:0] RstCode10     = 8'hE8;
    localparam logic [7:0] RstCode11     = 8'hEE;
    localparam logic [7:0] RstTrailer    = 8'hFE;
    localparam logic [8:0] RstBrightness = 9'd256;

    // configuration seen by the datapath
    typedef struct packed {
        logic [3:0][7:0] code_pair;
        logic [7:0]      trailer_code;
        logic [8:0]      brightness_scale;
    } t_cfg;

    // one classified pixel waiting for serialization
    typedef struct packed {
        logic [23:0] color;
        logic [7:0]  idx;
        logic        last;
    } t_pix;

    // (ch * scale) >> 8, saturated to 255
    function automatic logic [7:0] scale_channel(input logic [7:0] ch,
                                                 input logic [8:0] scale);
        logic [16:0] prod;
        prod = {9'd0, ch} * {8'd0, scale};
        return prod[16] ? 8'hFF : prod[15:8];
    endfunction

endpackage

// File: hw/rtl/aled_front.sv
`timescale 1ns / 1ps

module aled_front #(
    parameter int MAX_PIXELS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pixel_valid,
    output logic                o_pixel_stall,
    input  logic [23:0]         i_pixel_color,
    input  logic                i_last_pixel,
    input  logic [8:0]          i_brightness_scale,
    output logic                o_push,
    output aled_pkg::t_pix      o_push_pix,
    input  logic                i_queue_full
);
    import aled_pkg::*;

    // last position before the 8-bit counter wraps
    localparam int WrapInt = (MAX_PIXELS - 1 > 255) ? 255 : MAX_PIXELS - 1;
    localparam logic [7:0] WrapPoint = WrapInt[7:0];

    logic       r_valid;
    t_pix       r_pix;
    logic [7:0] r_pos;
    logic [7:0] n_pos;
    t_pix       n_pix;
    logic       w_accept;

    assign o_pixel_stall = r_valid && i_queue_full;
    assign w_accept      = i_pixel_valid && !o_pixel_stall;
    assign o_push        = r_valid && !i_queue_full;
    assign o_push_pix    = r_pix;

    // scale channels and tag with position
    always_comb begin
        n_pix.color = {scale_channel(i_pixel_color[23:16], i_brightness_scale),
                       scale_channel(i_pixel_color[15:8],  i_brightness_scale),
                       scale_channel(i_pixel_color[7:0],   i_brightness_scale)};
        n_pix.idx   = r_pos;
        n_pix.last  = i_last_pixel;
        if (i_last_pixel || (r_pos >= WrapPoint)) begin
            n_pos = 8'd0;
        end else begin
            n_pos = r_pos + 8'd1;
        end
    end

    // pixel counter and staging register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 8'd0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
            r_pos   <= n_pos;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix <= n_pix;
        end
    end

endmodule

// File: hw/rtl/aled_queue.sv
`timescale 1ns / 1ps

module aled_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  aled_pkg::t_pix i_push_pix,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output aled_pkg::t_pix o_pop_pix
);
    import aled_pkg::*;

    t_pix                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueueCntW-1:0] r_count;

    localparam logic [QueueCntW-1:0] FullCount = QueueCntW'(QueueDepth);

    assign o_full    = (r_count == FullCount);
    assign o_valid   = (r_count != '0);
    assign o_pop_pix = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_pix;
        end
    end

endmodule

// File: hw/rtl/aled_back.sv
`timescale 1ns / 1ps

module aled_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  aled_pkg::t_cfg i_cfg,
    input  logic           i_queue_valid,
    input  aled_pkg::t_pix i_queue_pix,
    output logic           o_pop,
    output logic           o_byte_valid,
    input  logic           i_byte_stall,
    output logic [7:0]     o_spi_byte,
    output logic [7:0]     o_pixel_index,
    output logic           o_run_end
);
    import aled_pkg::*;

    logic        r_busy;
    logic [23:0] r_word;
    logic [3:0]  r_cnt;
    logic [7:0]  r_idx;
    logic        r_last;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [7:0]  r_out_idx;
    logic        r_out_end;

    logic        w_adv;
    logic        w_emit;
    logic        w_is_trailer;
    logic        w_end;
    logic        w_fin;
    logic [7:0]  w_byte;

    // byte selection and completion
    always_comb begin
        w_adv        = !r_out_valid || !i_byte_stall;
        w_emit       = r_busy && w_adv;
        w_is_trailer = (r_cnt == BytesPerPixel);
        w_end        = w_is_trailer || ((r_cnt == LastColorByte) && !r_last);
        w_fin        = w_emit && w_end;
        w_byte       = w_is_trailer ? i_cfg.trailer_code : i_cfg.code_pair[r_word[1:0]];
        o_pop        = i_queue_valid && (!r_busy || w_fin);
    end

    // serializer state, next pixel loads as the current one finishes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (w_fin) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_queue_pix.color;
            r_idx  <= i_queue_pix.idx;
            r_last <= i_queue_pix.last;
            r_cnt  <= 4'd0;
        end else if (w_emit) begin
            r_word <= {2'b00, r_word[23:2]};
            r_cnt  <= r_cnt + 4'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_idx  <= r_idx;
            r_out_end  <= w_end;
        end
    end

    assign o_byte_valid  = r_out_valid;
    assign o_spi_byte    = r_out_byte;
    assign o_pixel_index = r_out_idx;
    assign o_run_end     = r_out_end;

endmodule

// File: hw/rtl/addressable_led_spi_encoder.sv
// A pixel passes the front staging register, the pixel queue, the serializer and the output register.
// The output register gives one byte per cycle while i_byte_stall is low; a pixel is 12 bytes,
// 13 when it is the last of a frame (trailer byte).
// A two-entry pixel queue lets the front take pixels while the serializer is busy.
// Reset (synchronous, active low) empties the pipeline, clears the pixel counter and
// restores the register defaults.
`timescale 1ns / 1ps

module addressable_led_spi_encoder #(
    parameter int MAX_PIXELS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_pixel_valid,
    output logic        o_pixel_stall,
    input  logic [23:0] i_pixel_color,
    input  logic        i_last_pixel,
    output logic        o_byte_valid,
    input  logic        i_byte_stall,
    output logic [7:0]  o_spi_byte,
    output logic [7:0]  o_pixel_index,
    output logic        o_run_end
);
    import aled_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_reg;
    logic     w_wr;
    logic     w_push;
    t_pix     w_push_pix;
    logic     w_full;
    logic     w_pop;
    logic     w_q_valid;
    t_pix     w_q_pix;

    assign pready = 1'b1;
    assign w_reg  = t_reg_idx'(paddr[PaddrW-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_pair[0]     <= RstCode00;
            r_cfg.code_pair[1]     <= RstCode01;
            r_cfg.code_pair[2]     <= RstCode10;
            r_cfg.code_pair[3]     <= RstCode11;
            r_cfg.trailer_code     <= RstTrailer;
            r_cfg.brightness_scale <= RstBrightness;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_CODE_00:    r_cfg.code_pair[0]     <= pwdata[7:0];
                REG_CODE_01:    r_cfg.code_pair[1]     <= pwdata[7:0];
                REG_CODE_10:    r_cfg.code_pair[2]     <= pwdata[7:0];
                REG_CODE_11:    r_cfg.code_pair[3]     <= pwdata[7:0];
                REG_TRAILER:    r_cfg.trailer_code     <= pwdata[7:0];
                REG_BRIGHTNESS: r_cfg.brightness_scale <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (w_reg)
            REG_CODE_00:    prdata = {24'd0, r_cfg.code_pair[0]};
            REG_CODE_01:    prdata = {24'd0, r_cfg.code_pair[1]};
            REG_CODE_10:    prdata = {24'd0, r_cfg.code_pair[2]};
            REG_CODE_11:    prdata = {24'd0, r_cfg.code_pair[3]};
            REG_TRAILER:    prdata = {24'd0, r_cfg.trailer_code};
            REG_BRIGHTNESS: prdata = {23'd0, r_cfg.brightness_scale};
            default:        prdata = 32'd0;
        endcase
    end

    // scaling and position tagging
    aled_front #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pixel_valid     (i_pixel_valid),
        .o_pixel_stall     (o_pixel_stall),
        .i_pixel_color     (i_pixel_color),
        .i_last_pixel      (i_last_pixel),
        .i_brightness_scale(r_cfg.brightness_scale),
        .o_push            (w_push),
        .o_push_pix        (w_push_pix),
        .i_queue_full      (w_full)
    );

    // pixel queue
    aled_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_pix(w_push_pix),
        .o_full    (w_full),
        .i_pop     (w_pop),
        .o_valid   (w_q_valid),
        .o_pop_pix (w_q_pix)
    );

    // byte serializer
    aled_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_queue_valid(w_q_valid),
        .i_queue_pix  (w_q_pix),
        .o_pop        (w_pop),
        .o_byte_valid (o_byte_valid),
        .i_byte_stall (i_byte_stall),
        .o_spi_byte   (o_spi_byte),
        .o_pixel_index(o_pixel_index),
        .o_run_end    (o_run_end)
    );

endmodule
